@@ design/ctli_pkg.sv @@
`default_nettype none
package ctli_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int STEP_W      = 5;
  localparam int DIV_W       = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  // Constants and codes
  localparam logic [31:0] NEG_ONE_Q16 = 32'hFFFF0000;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] KIND_VISIBLE  = 2'd0;
  localparam logic [1:0] KIND_INFRARED = 2'd1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_SEGMENT  = 2'd1;
  localparam logic [1:0] ST_BAD_KIND    = 2'd2;
  localparam logic [1:0] ST_ZERO_PERIOD = 2'd3;

  localparam logic REG_ENTRY_COUNT = 1'b0;

  // Program addresses
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t S_IDLE      = 5'd0;
  localparam step_t S_RD_PER    = 5'd1;
  localparam step_t S_CHK_PER   = 5'd2;
  localparam step_t S_MOD_WAIT  = 5'd3;
  localparam step_t S_SET_T     = 5'd4;
  localparam step_t S_RD_SEG    = 5'd5;
  localparam step_t S_CMP       = 5'd6;
  localparam step_t S_ADV       = 5'd7;
  localparam step_t S_MISS      = 5'd8;
  localparam step_t S_FOUND     = 5'd9;
  localparam step_t S_PREP      = 5'd10;
  localparam step_t S_MUL       = 5'd11;
  localparam step_t S_DIV       = 5'd12;
  localparam step_t S_DIV_WAIT  = 5'd13;
  localparam step_t S_LERP      = 5'd14;
  localparam step_t S_LEFT      = 5'd15;
  localparam step_t S_ERR_KIND  = 5'd16;
  localparam step_t S_ERR_PER   = 5'd17;
  localparam step_t S_EMIT      = 5'd18;
  localparam step_t S_WRITE_OUT = 5'd19;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_READ_PERIOD,
    OP_START_MOD,
    OP_SET_TIME,
    OP_READ_SEG,
    OP_ADVANCE,
    OP_MISS,
    OP_FOUND,
    OP_PREP,
    OP_MUL,
    OP_START_DIV,
    OP_LERP,
    OP_LEFT,
    OP_ERR_KIND,
    OP_ERR_PERIOD,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_QUERY,
    JC_ZERO_PERIOD,
    JC_DIV_BUSY,
    JC_NO_SEG,
    JC_HIT,
    JC_SEARCH_MORE,
    JC_BAD_KIND,
    JC_ZERO_WIDTH,
    JC_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  accept;
  } ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic no_query;
    logic zero_period;
    logic div_busy;
    logic no_seg;
    logic hit;
    logic search_more;
    logic bad_kind;
    logic zero_width;
    logic out_busy;
  } flags_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] hi;
    logic [DIV_W-1:0] lo;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [31:0] infrared;
    logic [31:0] visible;
    logic [31:0] tm;
  } entry_t;

  function automatic ucode_t mk(op_t op, cond_t cond, step_t target, logic accept);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.accept = accept;
    return w;
  endfunction

  // Control store: one word per step
  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t w;
    case (pc)
      S_IDLE:      w = mk(OP_NONE,        JC_NO_QUERY,    S_IDLE,     1'b1);
      S_RD_PER:    w = mk(OP_READ_PERIOD, JC_NEVER,       S_IDLE,     1'b0);
      S_CHK_PER:   w = mk(OP_START_MOD,   JC_ZERO_PERIOD, S_ERR_PER,  1'b0);
      S_MOD_WAIT:  w = mk(OP_NONE,        JC_DIV_BUSY,    S_MOD_WAIT, 1'b0);
      S_SET_T:     w = mk(OP_SET_TIME,    JC_NO_SEG,      S_MISS,     1'b0);
      S_RD_SEG:    w = mk(OP_READ_SEG,    JC_NEVER,       S_IDLE,     1'b0);
      S_CMP:       w = mk(OP_NONE,        JC_HIT,         S_FOUND,    1'b0);
      S_ADV:       w = mk(OP_ADVANCE,     JC_SEARCH_MORE, S_RD_SEG,   1'b0);
      S_MISS:      w = mk(OP_MISS,        JC_ALWAYS,      S_EMIT,     1'b0);
      S_FOUND:     w = mk(OP_FOUND,       JC_BAD_KIND,    S_ERR_KIND, 1'b0);
      S_PREP:      w = mk(OP_PREP,        JC_ZERO_WIDTH,  S_LEFT,     1'b0);
      S_MUL:       w = mk(OP_MUL,         JC_NEVER,       S_IDLE,     1'b0);
      S_DIV:       w = mk(OP_START_DIV,   JC_NEVER,       S_IDLE,     1'b0);
      S_DIV_WAIT:  w = mk(OP_NONE,        JC_DIV_BUSY,    S_DIV_WAIT, 1'b0);
      S_LERP:      w = mk(OP_LERP,        JC_ALWAYS,      S_EMIT,     1'b0);
      S_LEFT:      w = mk(OP_LEFT,        JC_ALWAYS,      S_EMIT,     1'b0);
      S_ERR_KIND:  w = mk(OP_ERR_KIND,    JC_ALWAYS,      S_EMIT,     1'b0);
      S_ERR_PER:   w = mk(OP_ERR_PERIOD,  JC_NEVER,       S_IDLE,     1'b0);
      S_EMIT:      w = mk(OP_NONE,        JC_OUT_BUSY,    S_EMIT,     1'b0);
      S_WRITE_OUT: w = mk(OP_EMIT,        JC_ALWAYS,      S_IDLE,     1'b0);
      default:     w = mk(OP_NONE,        JC_ALWAYS,      S_IDLE,     1'b0);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ design/ctli_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle. The caller guarantees
// hi < divisor so the quotient fits DIV_W bits.
module ctli_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ctli_pkg::div_req_t             req,
  output logic                                busy,
  output logic [ctli_pkg::DIV_W-1:0]          quot,
  output logic [ctli_pkg::DIV_W-1:0]          rem
);

  localparam int W = ctli_pkg::DIV_W;
  localparam logic [ctli_pkg::DIV_CNT_W-1:0] LAST_STEP = ctli_pkg::DIV_CNT_W'(W - 1);

  logic [W-1:0]                   rem_r, rem_nxt;
  logic [W-1:0]                   quo_r, quo_nxt;
  logic [W-1:0]                   div_r;
  logic [ctli_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic [W:0]                     trial;
  logic [W+1:0]                   diff;

  // One restoring step
  always_comb begin
    trial = {rem_r, quo_r[W-1]};
    diff  = {1'b0, trial} - {2'b00, div_r};
    if (!diff[W+1]) begin
      rem_nxt = diff[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.hi;
      quo_r <= req.lo;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

@@ design/ctli_sequencer.sv @@
`default_nettype none
// Step counter over the control store with conditional jumps.
module ctli_sequencer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctli_pkg::flags_t  flags,
  output ctli_pkg::ucode_t       ctl
);

  ctli_pkg::step_t  pc_r, pc_nxt;
  ctli_pkg::ucode_t word;
  logic             take;

  assign word = ctli_pkg::ucode_rom(pc_r);

  // Evaluate the jump condition of the current word
  always_comb begin
    case (word.cond)
      ctli_pkg::JC_NEVER:       take = 1'b0;
      ctli_pkg::JC_ALWAYS:      take = 1'b1;
      ctli_pkg::JC_NO_QUERY:    take = flags.no_query;
      ctli_pkg::JC_ZERO_PERIOD: take = flags.zero_period;
      ctli_pkg::JC_DIV_BUSY:    take = flags.div_busy;
      ctli_pkg::JC_NO_SEG:      take = flags.no_seg;
      ctli_pkg::JC_HIT:         take = flags.hit;
      ctli_pkg::JC_SEARCH_MORE: take = flags.search_more;
      ctli_pkg::JC_BAD_KIND:    take = flags.bad_kind;
      ctli_pkg::JC_ZERO_WIDTH:  take = flags.zero_width;
      ctli_pkg::JC_OUT_BUSY:    take = flags.out_busy;
      default:                  take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ctli_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl = word;

endmodule
`default_nettype wire

@@ design/ctli_datapath.sv @@
`default_nettype none
// Breakpoint table, search registers and interpolation arithmetic.
module ctli_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ctli_pkg::ucode_t                  ctl,
  input  wire logic [7:0]                        entry_count,
  input  wire logic                              in_valid,
  input  wire logic                              in_func,
  input  wire logic [7:0]                        in_entry_index,
  input  wire logic [31:0]                       in_entry_time,
  input  wire logic [31:0]                       in_entry_visible,
  input  wire logic [31:0]                       in_entry_infrared,
  input  wire logic [30:0]                       in_query_day,
  input  wire logic [24:0]                       in_query_fraction,
  input  wire logic [1:0]                        in_flux_kind,
  input  wire logic                              out_busy,
  output ctli_pkg::flags_t                       flags,
  output logic [31:0]                            res_flux,
  output logic [1:0]                             res_status,
  output logic [7:0]                             res_segment
);

  localparam int AW = ctli_pkg::ADDR_W;

  ctli_pkg::entry_t mem [ctli_pkg::TABLE_DEPTH];
  ctli_pkg::entry_t rd_a_r, rd_b_r, wr_entry;

  logic          accept, do_write;
  logic [AW-1:0] rd_a_addr, rd_b_addr;
  logic          rd_en;

  logic [30:0] day_r;
  logic [24:0] frac_r;
  logic [1:0]  kind_r;
  logic [31:0] t_r;
  logic [7:0]  seg_r, seg_nxt, cache_r, iter_r, start_seg;
  logic [7:0]  period;
  logic [8:0]  seg_inc, iter_inc;

  logic [31:0] v0_sel, v1_sel;
  logic [32:0] v_diff;
  logic [31:0] v0_r, mag_r, n_r, dt_r;
  logic        neg_r;
  logic [63:0] prod_r;

  ctli_pkg::div_req_t      div_req;
  logic                    div_busy;
  logic [ctli_pkg::DIV_W-1:0] div_quot, div_rem;

  logic [31:0] res_flux_r;
  logic [1:0]  res_status_r;
  logic [7:0]  res_seg_r;

  assign accept   = ctl.accept && in_valid;
  assign do_write = accept && (in_func == ctli_pkg::FUNC_WRITE);
  assign period   = rd_a_r.tm[31:24];

  assign wr_entry.tm       = in_entry_time;
  assign wr_entry.visible  = in_entry_visible;
  assign wr_entry.infrared = in_entry_infrared;

  // Table write port
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[in_entry_index[AW-1:0]] <= wr_entry;
    end
  end

  // Read addresses: period entry, or both ends of the current segment
  always_comb begin
    rd_en     = 1'b0;
    rd_a_addr = seg_r[AW-1:0];
    rd_b_addr = seg_inc[AW-1:0];
    case (ctl.op)
      ctli_pkg::OP_READ_PERIOD: begin
        rd_en     = 1'b1;
        rd_a_addr = entry_count[AW-1:0];
      end
      ctli_pkg::OP_READ_SEG: begin
        rd_en = 1'b1;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[rd_b_addr];
    end
  end

  // Capture query fields
  always_ff @(posedge clk) begin
    if (accept) begin
      day_r  <= in_query_day;
      frac_r <= in_query_fraction;
      kind_r <= in_flux_kind;
    end
  end

  // Search index arithmetic
  assign seg_inc   = {1'b0, seg_r} + 9'd1;
  assign iter_inc  = {1'b0, iter_r} + 9'd1;
  assign seg_nxt   = (seg_inc < {1'b0, entry_count}) ? seg_inc[7:0] : 8'd0;
  assign start_seg = (cache_r < entry_count) ? cache_r : 8'd0;

  // Flux operands of the requested kind
  always_comb begin
    if (kind_r == ctli_pkg::KIND_INFRARED) begin
      v0_sel = rd_a_r.infrared;
      v1_sel = rd_b_r.infrared;
    end else begin
      v0_sel = rd_a_r.visible;
      v1_sel = rd_b_r.visible;
    end
    v_diff = {v1_sel[31], v1_sel} - {v0_sel[31], v0_sel};
  end

  // Shared divider: day modulo period, then the interpolation quotient
  always_comb begin
    div_req.start   = 1'b0;
    div_req.hi      = prod_r[63:32];
    div_req.lo      = prod_r[31:0];
    div_req.divisor = dt_r;
    case (ctl.op)
      ctli_pkg::OP_START_MOD: begin
        div_req.start   = (period != 8'd0);
        div_req.hi      = '0;
        div_req.lo      = {1'b0, day_r};
        div_req.divisor = {24'd0, period};
      end
      ctli_pkg::OP_START_DIV: begin
        div_req.start = 1'b1;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  ctli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // Cached segment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_r <= 8'd0;
    end else if (ctl.op == ctli_pkg::OP_MISS) begin
      cache_r <= 8'd0;
    end else if (ctl.op == ctli_pkg::OP_FOUND) begin
      cache_r <= seg_r;
    end
  end

  // Search and arithmetic registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      ctli_pkg::OP_SET_TIME: begin
        t_r    <= {div_rem[7:0], 24'd0} + {7'd0, frac_r};
        seg_r  <= start_seg;
        iter_r <= 8'd0;
      end
      ctli_pkg::OP_ADVANCE: begin
        seg_r  <= seg_nxt;
        iter_r <= iter_inc[7:0];
      end
      ctli_pkg::OP_PREP: begin
        v0_r  <= v0_sel;
        neg_r <= v_diff[32];
        mag_r <= v_diff[32] ? 32'(-v_diff) : v_diff[31:0];
        n_r   <= t_r - rd_a_r.tm;
        dt_r  <= rd_b_r.tm - rd_a_r.tm;
      end
      ctli_pkg::OP_MUL: begin
        prod_r <= {32'd0, mag_r} * {32'd0, n_r};
      end
      default: begin
      end
    endcase
  end

  // Result registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      ctli_pkg::OP_MISS: begin
        res_flux_r   <= ctli_pkg::NEG_ONE_Q16;
        res_status_r <= ctli_pkg::ST_NO_SEGMENT;
        res_seg_r    <= 8'd0;
      end
      ctli_pkg::OP_LERP: begin
        res_flux_r   <= neg_r ? (v0_r - div_quot) : (v0_r + div_quot);
        res_status_r <= ctli_pkg::ST_OK;
        res_seg_r    <= seg_r;
      end
      ctli_pkg::OP_LEFT: begin
        res_flux_r   <= v0_r;
        res_status_r <= ctli_pkg::ST_OK;
        res_seg_r    <= seg_r;
      end
      ctli_pkg::OP_ERR_KIND: begin
        res_flux_r   <= ctli_pkg::NEG_ONE_Q16;
        res_status_r <= ctli_pkg::ST_BAD_KIND;
        res_seg_r    <= seg_r;
      end
      ctli_pkg::OP_ERR_PERIOD: begin
        res_flux_r   <= ctli_pkg::NEG_ONE_Q16;
        res_status_r <= ctli_pkg::ST_ZERO_PERIOD;
        res_seg_r    <= 8'd0;
      end
      default: begin
      end
    endcase
  end

  // Status for the sequencer
  always_comb begin
    flags.no_query    = !(in_valid && (in_func == ctli_pkg::FUNC_QUERY));
    flags.zero_period = (period == 8'd0);
    flags.div_busy    = div_busy;
    flags.no_seg      = (entry_count == 8'd0);
    flags.hit         = (t_r >= rd_a_r.tm) && (t_r <= rd_b_r.tm);
    flags.search_more = (iter_inc < {1'b0, entry_count});
    flags.bad_kind    = (kind_r != ctli_pkg::KIND_VISIBLE) &&
                        (kind_r != ctli_pkg::KIND_INFRARED);
    flags.zero_width  = (rd_b_r.tm <= rd_a_r.tm);
    flags.out_busy    = out_busy;
  end

  assign res_flux    = res_flux_r;
  assign res_status  = res_status_r;
  assign res_segment = res_seg_r;

endmodule
`default_nettype wire

@@ design/cyclic_table_linear_interpolator_top.sv @@
`default_nettype none
// Cyclic breakpoint table with linear interpolation. A write request (tuser 0)
// stores one entry; the block is ready again at once. A query request
// (tuser 1) reduces the day modulo the period entry, searches the segments
// cyclically from the cached one and interpolates the chosen flux. A query
// visits 1 to entry_count segments: each segment costs one table read, one
// compare and one advance step of the control program, and the shared
// one-bit-per-cycle divider computes both the modulo and the interpolation
// quotient. The next request is accepted once the result is in the output
// register, even while that result waits to be taken. The table is not
// cleared at reset; entries must be written before use.
module cyclic_table_linear_interpolator_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata, from bit 0: entry_index[7:0], entry_time[39:8],
  // entry_visible[71:40], entry_infrared[103:72], query_day[134:104],
  // query_fraction[159:135], flux_kind[161:160], zero fill [167:162]
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [167:0] in_tdata,
  // in_tuser: func (0 write entry, 1 query)
  input  wire logic         in_tuser,
  // out_tdata, from bit 0: flux_value[31:0], status[33:32],
  // segment_used[41:34], zero fill [47:42]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [47:0]       out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  ctli_pkg::ucode_t ctl;
  ctli_pkg::flags_t flags;

  logic [7:0]  entry_count_r;
  logic        cfg_wr;
  logic        out_valid_r;
  logic [31:0] out_flux_r, res_flux;
  logic [1:0]  out_status_r, res_status;
  logic [7:0]  out_seg_r, res_segment;
  logic        out_busy;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= 8'd1;
    end else if (cfg_wr && (cfg_paddr[2] == ctli_pkg::REG_ENTRY_COUNT)) begin
      entry_count_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == ctli_pkg::REG_ENTRY_COUNT) ?
                      {24'd0, entry_count_r} : 32'd0;

  assign out_busy = out_valid_r && !out_tready;

  ctli_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  ctli_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .entry_count       (entry_count_r),
    .in_valid          (in_tvalid),
    .in_func           (in_tuser),
    .in_entry_index    (in_tdata[7:0]),
    .in_entry_time     (in_tdata[39:8]),
    .in_entry_visible  (in_tdata[71:40]),
    .in_entry_infrared (in_tdata[103:72]),
    .in_query_day      (in_tdata[134:104]),
    .in_query_fraction (in_tdata[159:135]),
    .in_flux_kind      (in_tdata[161:160]),
    .out_busy          (out_busy),
    .flags             (flags),
    .res_flux          (res_flux),
    .res_status        (res_status),
    .res_segment       (res_segment)
  );

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.op == ctli_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == ctli_pkg::OP_EMIT) begin
      out_flux_r   <= res_flux;
      out_status_r <= res_status;
      out_seg_r    <= res_segment;
    end
  end

  assign in_tready  = ctl.accept;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_seg_r, out_status_r, out_flux_r};

  // A result is never loaded over one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == ctli_pkg::OP_EMIT) |-> !out_valid_r)
    else $error("result register overwritten");

  // An accepted query holds off further requests
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == ctli_pkg::FUNC_QUERY)) |=> !in_tready)
    else $error("ready while query in progress");

  // A table write completes in its acceptance cycle
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == ctli_pkg::FUNC_WRITE)) |=> in_tready)
    else $error("write request stalled the block");

endmodule
`default_nettype wire
